// ===== design/mpt_pkg.sv =====
// Shared types, constants and command/status bundles of the memory patch table.
package mpt_pkg;

    // Table geometry
    localparam int ENTRIES   = 64;
    localparam int ADDR_BITS = 24;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    // Fixed widths of the request and response fields
    localparam int MODE_W     = 3;
    localparam int SLOT_W     = 6;
    localparam int ADDR_W     = 24;
    localparam int BYTE_W     = 8;
    localparam int USED_W     = 7;

    // Request operation codes; the two codes above clear are rejected
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 3'd0,
        MODE_SET    = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_READ   = 3'd3,
        MODE_APPLY  = 3'd4,
        MODE_CLEAR  = 3'd5
    } mode_t;

    // One stored patch
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [BYTE_W-1:0]    data;
        logic                 on;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SET_WR,
        ST_DEL_CHK,
        ST_DEL_WR,
        ST_APP_CHK,
        ST_APP_EVAL,
        ST_APP_LAST,
        ST_RESP_OK,
        ST_RESP_FAIL,
        ST_RESP_READ
    } state_t;

    typedef enum logic [1:0] {
        RD_SLOT,
        RD_IDX,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_ADD,
        WR_SET,
        WR_SHIFT
    } wr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_SLOT,
        IDX_ZERO,
        IDX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        PEND_HOLD,
        PEND_CLR,
        PEND_LOAD
    } pend_op_t;

    typedef enum logic [1:0] {
        OUT_FAIL,
        OUT_OK,
        OUT_READ,
        OUT_WRITE
    } out_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic      req_load;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      wr_en;
        wr_sel_t   wr_sel;
        cnt_op_t   cnt_op;
        idx_op_t   idx_op;
        pend_op_t  pend_op;
        logic      out_load;
        out_kind_t out_kind;
        logic      out_last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  full;
        logic  slot_bad;
        logic  more_shift;
        logic  more_scan;
        logic  rd_on;
        logic  pend_valid;
        logic  out_free;
    } status_t;

endpackage

// ===== design/mpt_dp.sv =====
// Datapath of the memory patch table: request latch, entry memory, counters, result register.
module mpt_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mpt_pkg::cmd_t                cmd,
    output mpt_pkg::status_t             status,
    input  logic [mpt_pkg::MODE_W-1:0]   s_mode,
    input  logic [mpt_pkg::SLOT_W-1:0]   s_slot,
    input  logic [mpt_pkg::ADDR_W-1:0]   s_address,
    input  logic [mpt_pkg::BYTE_W-1:0]   s_value,
    input  logic                         s_enable,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic                         m_write_strobe,
    output logic [mpt_pkg::ADDR_W-1:0]   m_patch_address,
    output logic [mpt_pkg::BYTE_W-1:0]   m_patch_value,
    output logic                         m_entry_enabled,
    output logic [mpt_pkg::USED_W-1:0]   m_entries_used,
    output logic                         m_last
);
    import mpt_pkg::*;

    // Request latch
    logic [MODE_W-1:0]    req_mode_reg;
    logic [SLOT_W-1:0]    req_slot_reg;
    logic [ADDR_BITS-1:0] req_addr_reg;
    logic [BYTE_W-1:0]    req_value_reg;
    logic                 req_en_reg;

    // Entry store and its read port
    entry_t               entry_mem [ENTRIES];
    entry_t               rdata_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;

    // Counters and pending write
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     idx_plus;
    logic [CNT_W-1:0]     slot_idx;
    entry_t               pend_reg;
    logic                 pend_valid_reg, pend_valid_next;

    // Result register
    logic                 m_valid_reg, m_valid_next;
    logic                 ok_reg;
    logic                 strobe_reg;
    logic [ADDR_W-1:0]    paddr_reg;
    logic [BYTE_W-1:0]    pvalue_reg;
    logic                 pen_reg;
    logic [USED_W-1:0]    used_reg;
    logic                 last_reg;
    logic                 out_free;

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_mode_reg  <= s_mode;
            req_slot_reg  <= s_slot;
            req_addr_reg  <= ADDR_BITS'(s_address);
            req_value_reg <= s_value;
            req_en_reg    <= s_enable;
        end
    end

    assign idx_plus = idx_reg + CNT_W'(1);
    assign slot_idx = CNT_W'(req_slot_reg);

    always_comb begin
        unique case (cmd.rd_sel)
            RD_SLOT: rd_addr = slot_idx[IDX_W-1:0];
            RD_IDX:  rd_addr = idx_reg[IDX_W-1:0];
            RD_NEXT: rd_addr = idx_plus[IDX_W-1:0];
            default: rd_addr = idx_reg[IDX_W-1:0];
        endcase
    end

    always_comb begin
        unique case (cmd.wr_sel)
            WR_ADD: begin
                wr_addr = count_reg[IDX_W-1:0];
                wr_data = '{addr: req_addr_reg, data: req_value_reg, on: req_en_reg};
            end
            WR_SET: begin
                wr_addr = slot_idx[IDX_W-1:0];
                wr_data = '{addr: rdata_reg.addr, data: rdata_reg.data, on: req_en_reg};
            end
            WR_SHIFT: begin
                wr_addr = idx_reg[IDX_W-1:0];
                wr_data = rdata_reg;
            end
            default: begin
                wr_addr = idx_reg[IDX_W-1:0];
                wr_data = rdata_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= entry_mem[rd_addr];
        end
    end

    always_comb begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CNT_W'(1);
            CNT_DEC: count_next = count_reg - CNT_W'(1);
            CNT_CLR: count_next = '0;
            default: count_next = count_reg;
        endcase
        case (cmd.idx_op)
            IDX_SLOT: idx_next = slot_idx;
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_plus;
            default:  idx_next = idx_reg;
        endcase
        case (cmd.pend_op)
            PEND_CLR:  pend_valid_next = 1'b0;
            PEND_LOAD: pend_valid_next = 1'b1;
            default:   pend_valid_next = pend_valid_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pend_op == PEND_LOAD) begin
            pend_reg <= rdata_reg;
        end
    end

    // Result register: load replaces, a taken result drops valid
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            // hold the count with the result; the next request may change it meanwhile
            used_reg <= USED_W'(count_reg);
            case (cmd.out_kind)
                OUT_OK: begin
                    ok_reg     <= 1'b1;
                    strobe_reg <= 1'b0;
                    paddr_reg  <= '0;
                    pvalue_reg <= '0;
                    pen_reg    <= 1'b0;
                    last_reg   <= 1'b1;
                end
                OUT_READ: begin
                    ok_reg     <= 1'b1;
                    strobe_reg <= 1'b0;
                    paddr_reg  <= ADDR_W'(rdata_reg.addr);
                    pvalue_reg <= rdata_reg.data;
                    pen_reg    <= rdata_reg.on;
                    last_reg   <= 1'b1;
                end
                OUT_WRITE: begin
                    ok_reg     <= 1'b1;
                    strobe_reg <= 1'b1;
                    paddr_reg  <= ADDR_W'(pend_reg.addr);
                    pvalue_reg <= pend_reg.data;
                    pen_reg    <= 1'b0;
                    last_reg   <= cmd.out_last;
                end
                default: begin
                    ok_reg     <= 1'b0;
                    strobe_reg <= 1'b0;
                    paddr_reg  <= '0;
                    pvalue_reg <= '0;
                    pen_reg    <= 1'b0;
                    last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ok            = ok_reg;
    assign m_write_strobe  = strobe_reg;
    assign m_patch_address = paddr_reg;
    assign m_patch_value   = pvalue_reg;
    assign m_entry_enabled = pen_reg;
    assign m_entries_used  = used_reg;
    assign m_last          = last_reg;

    assign status.mode       = mode_t'(req_mode_reg);
    assign status.full       = (count_reg == CNT_W'(ENTRIES));
    assign status.slot_bad   = (32'(req_slot_reg) >= 32'(count_reg));
    assign status.more_shift = (idx_plus < count_reg);
    assign status.more_scan  = (idx_reg < count_reg);
    assign status.rd_on      = rdata_reg.on;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count above table size");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while stalled");

    a_write_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && cmd.out_kind == OUT_WRITE) |-> pend_valid_reg)
        else $error("patch write issued without a pending entry");

    a_add_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_en && cmd.wr_sel == WR_ADD) |-> (count_reg < CNT_W'(ENTRIES)))
        else $error("append into a full table");
`endif

endmodule

// ===== design/mpt_ctrl.sv =====
// Controller of the memory patch table: sequences each request over the datapath.
module mpt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mpt_pkg::status_t status,
    output mpt_pkg::cmd_t    cmd
);
    import mpt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.rd_sel   = RD_SLOT;
        cmd.wr_sel   = WR_ADD;
        cmd.cnt_op   = CNT_HOLD;
        cmd.idx_op   = IDX_HOLD;
        cmd.pend_op  = PEND_HOLD;
        cmd.out_kind = OUT_FAIL;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.req_load = s_valid;
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (status.mode)
                    MODE_ADD: begin
                        if (status.full) begin
                            state_next = ST_RESP_FAIL;
                        end else begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WR_ADD;
                            cmd.cnt_op = CNT_INC;
                            state_next = ST_RESP_OK;
                        end
                    end
                    MODE_SET: begin
                        if (status.slot_bad) begin
                            state_next = ST_RESP_FAIL;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_SLOT;
                            state_next = ST_SET_WR;
                        end
                    end
                    MODE_DELETE: begin
                        if (status.slot_bad) begin
                            state_next = ST_RESP_FAIL;
                        end else begin
                            cmd.idx_op = IDX_SLOT;
                            state_next = ST_DEL_CHK;
                        end
                    end
                    MODE_READ: begin
                        if (status.slot_bad) begin
                            state_next = ST_RESP_FAIL;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_SLOT;
                            state_next = ST_RESP_READ;
                        end
                    end
                    MODE_APPLY: begin
                        cmd.idx_op  = IDX_ZERO;
                        cmd.pend_op = PEND_CLR;
                        state_next  = ST_APP_CHK;
                    end
                    MODE_CLEAR: begin
                        cmd.cnt_op = CNT_CLR;
                        state_next = ST_RESP_OK;
                    end
                    default: begin
                        state_next = ST_RESP_FAIL;
                    end
                endcase
            end
            ST_SET_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SET;
                state_next = ST_RESP_OK;
            end
            ST_DEL_CHK: begin
                if (status.more_shift) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    state_next = ST_DEL_WR;
                end else begin
                    cmd.cnt_op = CNT_DEC;
                    state_next = ST_RESP_OK;
                end
            end
            ST_DEL_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.idx_op = IDX_INC;
                state_next = ST_DEL_CHK;
            end
            ST_APP_CHK: begin
                if (status.more_scan) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    cmd.idx_op = IDX_INC;
                    state_next = ST_APP_EVAL;
                end else if (status.pend_valid) begin
                    state_next = ST_APP_LAST;
                end else begin
                    state_next = ST_RESP_OK;
                end
            end
            ST_APP_EVAL: begin
                if (!status.rd_on) begin
                    state_next = ST_APP_CHK;
                end else if (!status.pend_valid) begin
                    cmd.pend_op = PEND_LOAD;
                    state_next  = ST_APP_CHK;
                end else if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_WRITE;
                    cmd.out_last = 1'b0;
                    cmd.pend_op  = PEND_LOAD;
                    state_next   = ST_APP_CHK;
                end
            end
            ST_APP_LAST: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_WRITE;
                    cmd.out_last = 1'b1;
                    cmd.pend_op  = PEND_CLR;
                    state_next   = ST_IDLE;
                end
            end
            ST_RESP_OK: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_OK;
                    state_next   = ST_IDLE;
                end
            end
            ST_RESP_FAIL: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_FAIL;
                    state_next   = ST_IDLE;
                end
            end
            ST_RESP_READ: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_READ;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted request not decoded");

    a_one_port_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd_en && cmd.wr_en))
        else $error("read and write of the entry store in one cycle");

    a_shift_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEL_WR) |-> $past(cmd.rd_en))
        else $error("shift written without a fresh read");
`endif

endmodule

// ===== design/memory_patch_table_top.sv =====
// Top level of the memory patch table: request and result channels around controller and datapath.
//
// The table holds up to 64 patches (24-bit address, data byte, enable flag) packed
// densely in list order. One request is worked on at a time; s_ready is high only
// while the controller is idle, and the single result register lets the next
// request in while an earlier result waits for m_ready. Cycles per request, from
// acceptance to the result being loaded, with the result side not stalling:
// add, clear, read, rejected mode or bad slot take 2; set enable 3; delete
// 3 + 2*(count before the request - slot - 1), since each later entry moves down
// through one read and one write of the single-ported entry store; apply
// 3 + 2*entries_used to its final result, as every entry is read once over that
// port and each enabled one is held back a step so that the final write can carry
// last. The next request can be accepted in the cycle after the result is loaded.
// Apply sends one result per enabled entry (write_strobe high, last
// on the final one) or a single plain ok result when none is enabled; every other
// mode sends exactly one result with last high. entries_used always reports the
// count after the request. The entry store has no reset: an entry is only ever
// read at an index below the count, so nothing reachable is unwritten.
module memory_patch_table_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [5:0]  s_slot,
    input  logic [23:0] s_address,
    input  logic [7:0]  s_value,
    input  logic        s_enable,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic        m_write_strobe,
    output logic [23:0] m_patch_address,
    output logic [7:0]  m_patch_value,
    output logic        m_entry_enabled,
    output logic [6:0]  m_entries_used,
    output logic        m_last
);
    import mpt_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence each request
    mpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold the request, the entry store and the result register
    mpt_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_mode          (s_mode),
        .s_slot          (s_slot),
        .s_address       (s_address),
        .s_value         (s_value),
        .s_enable        (s_enable),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_write_strobe  (m_write_strobe),
        .m_patch_address (m_patch_address),
        .m_patch_value   (m_patch_value),
        .m_entry_enabled (m_entry_enabled),
        .m_entries_used  (m_entries_used),
        .m_last          (m_last)
    );

endmodule
